// ----- src/jvs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jvs_pkg
// Shared widths, reset values, register codes and FSM states of the joint
// velocity servo with strain filter.
// ----------------------------------------------------------------------------
package jvs_pkg;

  // Field widths
  localparam int JW     = 2;
  localparam int CMD_W  = 32;
  localparam int RAW_W  = 8;
  localparam int DT_W   = 20;
  localparam int CNT_W  = 16;

  // Configuration register widths
  localparam int TAU_W  = 22;
  localparam int DZ_W   = 24;
  localparam int OFF_W  = 8;
  localparam int SG_W   = 16;
  localparam int PG_W   = 16;
  localparam int LIM_W  = 31;
  localparam int CPR_W  = 20;
  localparam int CFG_DW = 31;
  localparam int CFG_IW = 3;

  // Filtered strain state, Q16.16 in 32 bits
  localparam int FS_W   = 32;
  localparam int FRAC   = 16;
  localparam int HALF   = 2 ** (FRAC - 1);

  // Datapath widths
  localparam int DIFF_W = RAW_W + 1;
  localparam int XD_W   = DIFF_W + DT_W + 1;
  localparam int OT_W   = FS_W + TAU_W + 1;
  localparam int NS_W   = OT_W + 1;
  localparam int NUM_W  = NS_W + 2;
  localparam int DEN_W  = TAU_W + 2;
  localparam int QP_W   = SG_W + 1 + FS_W;
  localparam int QF_W   = QP_W - FRAC;
  localparam int E_W    = QF_W + 2;
  localparam int PP_W   = PG_W + 1 + E_W;
  localparam int CP_W   = CMD_W + CPR_W + 1;
  localparam int CQ_W   = CP_W - FRAC;
  localparam int CNT_MAX = 2 ** (CNT_W - 1) - 1;

  localparam int NUM_JOINTS_DEF = 3;

  // Reset values
  localparam logic [TAU_W-1:0] TAU_RST = TAU_W'(300000);
  localparam logic [DZ_W-1:0]  DZ_RST  = DZ_W'(19661);
  localparam logic [OFF_W-1:0] OFF_RST = OFF_W'(126);
  localparam logic [SG_W-1:0]  SG_RST  = SG_W'(1638);
  localparam logic [PG_W-1:0]  PG_RST  = PG_W'(3277);
  localparam logic [LIM_W-1:0] LIM_RST = LIM_W'(262);
  localparam logic [CPR_W-1:0] CPR_RST = CPR_W'(81439);

  typedef enum logic [CFG_IW-1:0] {
    REG_TAU = 3'd0,
    REG_DZ  = 3'd1,
    REG_OFF = 3'd2,
    REG_SG  = 3'd3,
    REG_PG  = 3'd4,
    REG_LIM = 3'd5,
    REG_CPR = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_SUM,
    S_DIV,
    S_DZ,
    S_ERR,
    S_PMUL,
    S_CLAMP,
    S_VEL,
    S_CNT,
    S_SAT,
    S_DONE
  } jvs_state_t;

endpackage

// ----- src/jvs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jvs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 3,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/jvs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jvs_div
// Iterative signed floor divider, two restoring steps per clock. Signed
// dividend, positive unsigned divisor; quotient truncated to QW bits.
// ----------------------------------------------------------------------------
module jvs_div #(
  parameter int NW = 58,
  parameter int DW = 24,
  parameter int QW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic [DW-1:0]        den,
  output logic                 done,
  output logic signed [QW-1:0] quo
);

  localparam int STEPS = (NW + 1) / 2;
  localparam int MW    = 2 * STEPS;
  localparam int CW    = $clog2(STEPS + 1);

  logic [MW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, fin_r;

  logic [NW-1:0] mag;
  logic [DW:0]   t1, t2;
  logic [DW-1:0] r1;
  logic          q1, q2;
  logic [QW-1:0] q;

  always_comb begin
    mag     = num[NW-1] ? NW'(-num) : NW'(num);
    t1      = {rem_r, quo_r[MW-1]};
    q1      = (t1 >= {1'b0, den_r});
    r1      = q1 ? DW'(t1 - {1'b0, den_r}) : t1[DW-1:0];
    t2      = {r1, quo_r[MW-2]};
    q2      = (t2 >= {1'b0, den_r});
    rem_nxt = q2 ? DW'(t2 - {1'b0, den_r}) : t2[DW-1:0];
    quo_nxt = {quo_r[MW-3:0], q1, q2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= MW'(mag);
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[NW-1];
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // floor for negative dividends: -(q+1) = ~q when a remainder is left
  assign q    = quo_r[QW-1:0];
  assign done = fin_r;
  assign quo  = neg_r ? ((rem_r != '0) ? ~q : (~q + QW'(1))) : q;

endmodule

// ----- src/joint_velocity_servo_with_strain_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_velocity_servo_with_strain_filter_core
// Per-joint velocity servo: velocity clamp, or position control with a
// low-pass filtered, deadzoned strain correction held in a per-joint RAM.
// ----------------------------------------------------------------------------
// Channel  Direction  Ports                                        Transfer
// in       input      in_valid/in_stall, in_joint .. in_elapsed_us valid & !stall
// out      output     out_valid/out_stall, out_joint_out,          valid & !stall
//                     out_velocity_counts
// cfg      input      cfg_we, cfg_idx, cfg_wdata                   cfg_we
//
// A position tick may wait on the low-pass divider (29 radix-4 iterations);
// a velocity tick skips it, and a bad joint index goes straight to the result.
// One tick at a time; the next is taken while the result waits in the output
// register. Reset clears the filtered strain of every joint (valid bits).
// out_stall only holds the final stage; in_stall is high while a tick works.
// ----------------------------------------------------------------------------
module joint_velocity_servo_with_strain_filter_core import jvs_pkg::*; #(
  parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [JW-1:0]            in_joint,
  input  logic                     in_func,
  input  logic signed [CMD_W-1:0]  in_command,
  input  logic signed [CMD_W-1:0]  in_measured_position,
  input  logic [RAW_W-1:0]         in_strain_raw,
  input  logic [DT_W-1:0]          in_elapsed_us,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [JW-1:0]            out_joint_out,
  output logic signed [CNT_W-1:0]  out_velocity_counts,
  input  logic                     cfg_we,
  input  logic [CFG_IW-1:0]        cfg_idx,
  input  logic [CFG_DW-1:0]        cfg_wdata
);

  localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  jvs_state_t st_r, st_nxt;

  logic [TAU_W-1:0] tau_r;
  logic [DZ_W-1:0]  dz_r;
  logic [OFF_W-1:0] off_r;
  logic [SG_W-1:0]  sg_r;
  logic [PG_W-1:0]  pg_r;
  logic [LIM_W-1:0] lim_r;
  logic [CPR_W-1:0] cpr_r;

  logic              in_acc, jok, out_load, div_start, div_done, ram_we;
  logic [AW+JW-1:0]  jext;
  logic [AW-1:0]     in_addr, addr_r;
  logic [JW-1:0]     joint_r;
  logic              func_r, jok_r;
  logic signed [CMD_W-1:0] cmd_r, meas_r;
  logic [RAW_W-1:0]  raw_r;
  logic [DT_W-1:0]   dt_r;
  logic [NUM_JOINTS-1:0] vld_r;
  logic [FS_W-1:0]   ram_rdata;

  logic signed [FS_W-1:0]   old, old_r, y_r, s, div_quo;
  logic signed [DIFF_W-1:0] diff;
  logic signed [XD_W-1:0]   xd, xd_r;
  logic signed [OT_W-1:0]   ot, ot_r;
  logic signed [NS_W-1:0]   nsum;
  logic [DEN_W-2:0]         den;
  logic signed [NUM_W-1:0]  num;
  logic signed [FS_W:0]     dx, dzp, dzn;
  logic                     in_dz;
  logic signed [QP_W-1:0]   qp, qp_r, qr;
  logic signed [QF_W-1:0]   qf;
  logic signed [E_W-1:0]    e, e_r;
  logic signed [PP_W-1:0]   pp, pp_r, limp, limn, pc, pr;
  logic signed [CMD_W:0]    limv, limvn, vsel;
  logic signed [CMD_W-1:0]  v_pos, v_vel, v_r;
  logic signed [CP_W-1:0]   cp, cp_r, cr;
  logic signed [CQ_W-1:0]   cq;
  logic signed [CNT_W-1:0]  cnt_sat, cnt_r;
  logic                     out_valid_r;
  logic [JW-1:0]            out_joint_r;
  logic signed [CNT_W-1:0]  out_cnt_r;

  // ---------------------------------------------------------------- input
  assign in_acc  = in_valid && !in_stall;
  assign jok     = (int'(in_joint) < NUM_JOINTS);
  assign jext    = {{AW{1'b0}}, in_joint};
  assign in_addr = jext[AW-1:0];

  // ---------------------------------------------------------------- FSM
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!jok) st_nxt = S_DONE;
          else if (!in_func) st_nxt = S_VEL;
          else st_nxt = S_READ;
        end
      end
      S_READ:  st_nxt = S_SUM;
      S_SUM:   st_nxt = (den != '0) ? S_DIV : S_DZ;
      S_DIV:   st_nxt = div_done ? S_DZ : S_DIV;
      S_DZ:    st_nxt = S_ERR;
      S_ERR:   st_nxt = S_PMUL;
      S_PMUL:  st_nxt = S_CLAMP;
      S_CLAMP: st_nxt = S_CNT;
      S_VEL:   st_nxt = S_CNT;
      S_CNT:   st_nxt = S_SAT;
      S_SAT:   st_nxt = S_DONE;
      S_DONE:  st_nxt = (!out_valid_r || !out_stall) ? S_IDLE : S_DONE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    case (st_r)
      S_IDLE:  in_stall  = 1'b0;
      S_SUM:   div_start = (den != '0);
      S_DZ:    ram_we    = 1'b1;
      S_DONE:  out_load  = !out_valid_r || !out_stall;
      default: in_stall  = 1'b1;
    endcase
  end

  // ---------------------------------------------------------------- state RAM
  jvs_ram #(
    .WIDTH (FS_W),
    .DEPTH (NUM_JOINTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (addr_r),
    .wr_data (y_r),
    .rd_addr (in_addr),
    .rd_data (ram_rdata)
  );

  jvs_div #(
    .NW (NUM_W),
    .DW (DEN_W),
    .QW (FS_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   ({den, 1'b0}),
    .done  (div_done),
    .quo   (div_quo)
  );

  // ---------------------------------------------------------------- datapath
  always_comb begin
    old   = vld_r[addr_r] ? $signed(ram_rdata) : '0;
    diff  = $signed({1'b0, raw_r}) - $signed({1'b0, off_r});
    xd    = diff * $signed({1'b0, dt_r});
    ot    = old * $signed({1'b0, tau_r});

    // round half up: floor((2n + d) / 2d)
    nsum  = $signed({xd_r, {FRAC{1'b0}}}) + ot_r;
    den   = {1'b0, tau_r} + (TAU_W + 1)'(dt_r);
    num   = $signed({nsum, 1'b0}) + $signed({{(NUM_W - DEN_W + 1){1'b0}}, den});

    dx    = y_r - old_r;
    dzp   = $signed({{(FS_W - DZ_W + 1){1'b0}}, dz_r});
    dzn   = -dzp;
    in_dz = (dx < dzp) && (dx > dzn);
    s     = in_dz ? old_r : y_r;
    qp    = $signed({1'b0, sg_r}) * s;

    qr    = qp_r + QP_W'(HALF);
    qf    = qr[QP_W-1:FRAC];
    e     = cmd_r - meas_r - qf;
    pp    = $signed({1'b0, pg_r}) * e_r;

    limp  = $signed({{(PP_W - LIM_W - FRAC){1'b0}}, lim_r, {FRAC{1'b0}}});
    limn  = -limp;
    if (pp_r > limp) pc = limp;
    else if (pp_r < limn) pc = limn;
    else pc = pp_r;
    pr    = pc + PP_W'(HALF);
    v_pos = pr[FRAC+CMD_W-1:FRAC];

    limv  = $signed({2'b00, lim_r});
    limvn = -limv;
    if (cmd_r > limv) vsel = limv;
    else if (cmd_r < limvn) vsel = limvn;
    else vsel = cmd_r;
    v_vel = vsel[CMD_W-1:0];

    cp    = v_r * $signed({1'b0, cpr_r});
    cr    = cp_r + CP_W'(HALF);
    cq    = cr[CP_W-1:FRAC];
    if (cq > $signed(CQ_W'(CNT_MAX))) cnt_sat = CNT_W'(CNT_MAX);
    else if (cq < $signed(CQ_W'(-CNT_MAX - 1))) cnt_sat = CNT_W'(-CNT_MAX - 1);
    else cnt_sat = cq[CNT_W-1:0];
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      tau_r       <= TAU_RST;
      dz_r        <= DZ_RST;
      off_r       <= OFF_RST;
      sg_r        <= SG_RST;
      pg_r        <= PG_RST;
      lim_r       <= LIM_RST;
      cpr_r       <= CPR_RST;
    end else begin
      st_r <= st_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (ram_we) vld_r[addr_r] <= 1'b1;
      if (cfg_we) begin
        case (cfg_idx)
          REG_TAU: tau_r <= cfg_wdata[TAU_W-1:0];
          REG_DZ:  dz_r  <= cfg_wdata[DZ_W-1:0];
          REG_OFF: off_r <= cfg_wdata[OFF_W-1:0];
          REG_SG:  sg_r  <= cfg_wdata[SG_W-1:0];
          REG_PG:  pg_r  <= cfg_wdata[PG_W-1:0];
          REG_LIM: lim_r <= cfg_wdata[LIM_W-1:0];
          REG_CPR: cpr_r <= cfg_wdata[CPR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    if (in_acc) begin
      joint_r <= in_joint;
      func_r  <= in_func;
      jok_r   <= jok;
      addr_r  <= in_addr;
      cmd_r   <= in_command;
      meas_r  <= in_measured_position;
      raw_r   <= in_strain_raw;
      dt_r    <= in_elapsed_us;
      cnt_r   <= '0;
    end
    if (st_r == S_READ) begin
      old_r <= old;
      xd_r  <= xd;
      ot_r  <= ot;
    end
    if (st_r == S_SUM) y_r <= old_r;
    if (st_r == S_DIV && div_done) y_r <= div_quo;
    if (st_r == S_DZ) qp_r <= qp;
    if (st_r == S_ERR) e_r <= e;
    if (st_r == S_PMUL) pp_r <= pp;
    if (st_r == S_CLAMP) v_r <= v_pos;
    if (st_r == S_VEL) v_r <= v_vel;
    if (st_r == S_CNT) cp_r <= cp;
    if (st_r == S_SAT) cnt_r <= cnt_sat;
    if (out_load) begin
      out_joint_r <= joint_r;
      out_cnt_r   <= cnt_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_joint_out       = out_joint_r;
  assign out_velocity_counts = out_cnt_r;

`ifndef SYNTH
  a_bad_joint_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (int'(out_joint_out) >= NUM_JOINTS)) |-> (out_velocity_counts == '0))
    else $error("out-of-range joint produced nonzero counts");

  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == S_DIV))
    else $error("divider finished outside its wait state");

  a_ram_wr_pos: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (jok_r && func_r))
    else $error("strain RAM written for a non-position or bad-joint tick");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(st_r == S_DONE))
    else $error("result presented without finishing a tick");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the joint velocity servo with strain filter. A
// directed table (extremes, bad joint, zero filter denominator, register
// masking) is followed by randomized ticks over several register settings.
// Every result transfer is checked against a fixed-point servo predictor or a
// typed count, with random idling on both channels but in the last two phases.
// ----------------------------------------------------------------------------
module testbench;
  import jvs_pkg::*;

  localparam int NUM_JOINTS  = NUM_JOINTS_DEF;
  localparam int PHASES      = 8;
  localparam int PHASE_TICKS = 200;
  localparam int N_DIRECTED  = 22;

  localparam logic FUNC_VEL = 1'b0;
  localparam logic FUNC_POS = 1'b1;
  localparam logic [JW-1:0]     JOINT_BAD = 2'd3;
  localparam logic [CFG_IW-1:0] REG_NONE  = 3'd7;

  localparam logic signed [CMD_W-1:0] CMD_MAX = 32'sh7fff_ffff;
  localparam logic signed [CMD_W-1:0] CMD_MIN = 32'sh8000_0000;
  localparam logic [DT_W-1:0]         DT_MAX  = 20'd1000000;
  localparam logic [DT_W-1:0]         DT_FULL = 20'hfffff;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    logic [JW-1:0]           joint;
    logic                    func;
    logic signed [CMD_W-1:0] command;
    logic signed [CMD_W-1:0] measured;
    logic [RAW_W-1:0]        raw;
    logic [DT_W-1:0]         dt;
  } servo_tick_t;

  typedef struct {
    logic [JW-1:0]           joint;
    logic signed [CNT_W-1:0] counts;
  } servo_out_t;

  typedef struct {
    row_kind_t               kind;
    logic [JW-1:0]           joint;
    logic                    func;
    logic signed [CMD_W-1:0] command;
    logic signed [CMD_W-1:0] measured;
    logic [RAW_W-1:0]        raw;
    logic [DT_W-1:0]         dt;
    logic [CFG_IW-1:0]       reg_idx;
    logic [CFG_DW-1:0]       reg_data;
    bit                      typed;
    logic signed [CNT_W-1:0] typed_counts;
  } plan_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [JW-1:0]           in_joint;
  logic                    in_func;
  logic signed [CMD_W-1:0] in_command;
  logic signed [CMD_W-1:0] in_measured_position;
  logic [RAW_W-1:0]        in_strain_raw;
  logic [DT_W-1:0]         in_elapsed_us;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [JW-1:0]           out_joint_out;
  logic signed [CNT_W-1:0] out_velocity_counts;
  logic                    cfg_we;
  logic [CFG_IW-1:0]       cfg_idx;
  logic [CFG_DW-1:0]       cfg_wdata;

  // register mirror and per-joint filtered strain
  longint cfg_tau      = TAU_RST;
  longint cfg_deadzone = DZ_RST;
  longint cfg_offset   = OFF_RST;
  longint cfg_sgain    = SG_RST;
  longint cfg_pgain    = PG_RST;
  longint cfg_vlimit   = LIM_RST;
  longint cfg_cpr      = CPR_RST;
  longint strain_state [NUM_JOINTS] = '{default: 0};

  servo_out_t expected_q [$];
  int         error_count   = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         strain_level [4] = '{126, 126, 126, 126};

  plan_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_TICK, 2'd0, FUNC_VEL, CMD_MAX, 32'sd0, 8'd0, 20'd0, REG_TAU, 31'd0, 1'b1, 16'sd326},
    '{ROW_TICK, 2'd1, FUNC_VEL, CMD_MIN, 32'sd0, 8'd255, 20'd0, REG_TAU, 31'd0, 1'b1,
      -16'sd326},
    '{ROW_TICK, 2'd2, FUNC_VEL, 32'sd0, CMD_MAX, 8'd126, 20'd0, REG_TAU, 31'd0, 1'b1, 16'sd0},
    '{ROW_TICK, JOINT_BAD, FUNC_VEL, 32'sh1234_5678, 32'sd0, 8'd0, 20'd0, REG_TAU, 31'd0,
      1'b1, 16'sd0},
    '{ROW_TICK, JOINT_BAD, FUNC_POS, CMD_MAX, CMD_MIN, 8'd255, DT_MAX, REG_TAU, 31'd0,
      1'b1, 16'sd0},
    '{ROW_TICK, 2'd0, FUNC_POS, 32'sd0, 32'sd0, 8'd126, 20'd1000, REG_TAU, 31'd0, 1'b1,
      16'sd0},
    '{ROW_TICK, 2'd0, FUNC_POS, CMD_MAX, CMD_MIN, 8'd255, DT_MAX, REG_TAU, 31'd0, 1'b1,
      16'sd326},
    '{ROW_TICK, 2'd1, FUNC_POS, CMD_MIN, CMD_MAX, 8'd0, DT_MAX, REG_TAU, 31'd0, 1'b1,
      -16'sd326},
    '{ROW_TICK, 2'd2, FUNC_POS, 32'sh0001_0000, 32'sd0, 8'd255, 20'd0, REG_TAU, 31'd0,
      1'b0, 16'sd0},
    '{ROW_TICK, 2'd0, FUNC_POS, 32'sh0001_0000, 32'sd0, 8'd200, 20'd50000, REG_TAU, 31'd0,
      1'b0, 16'sd0},
    '{ROW_TICK, 2'd0, FUNC_POS, 32'sh0001_0000, 32'sd0, 8'd200, 20'd10, REG_TAU, 31'd0,
      1'b0, 16'sd0},
    '{ROW_TICK, 2'd2, FUNC_POS, 32'shffff_0000, 32'sh0000_8000, 8'd0, DT_FULL, REG_TAU,
      31'd0, 1'b0, 16'sd0},
    '{ROW_CFG, 2'd0, FUNC_VEL, 32'sd0, 32'sd0, 8'd0, 20'd0, REG_TAU, 31'd0, 1'b0, 16'sd0},
    '{ROW_TICK, 2'd1, FUNC_POS, 32'sh0002_0000, 32'sd0, 8'd255, 20'd0, REG_TAU, 31'd0,
      1'b0, 16'sd0},
    '{ROW_TICK, 2'd1, FUNC_POS, 32'sd0, 32'sh0001_0000, 8'd10, 20'd1, REG_TAU, 31'd0,
      1'b0, 16'sd0},
    '{ROW_CFG, 2'd0, FUNC_VEL, 32'sd0, 32'sd0, 8'd0, 20'd0, REG_NONE, 31'h7fff_ffff,
      1'b0, 16'sd0},
    '{ROW_CFG, 2'd0, FUNC_VEL, 32'sd0, 32'sd0, 8'd0, 20'd0, REG_OFF, 31'h7fff_ff80,
      1'b0, 16'sd0},
    '{ROW_CFG, 2'd0, FUNC_VEL, 32'sd0, 32'sd0, 8'd0, 20'd0, REG_CPR, 31'h7fff_ffff,
      1'b0, 16'sd0},
    '{ROW_TICK, 2'd0, FUNC_VEL, CMD_MAX, 32'sd0, 8'd0, 20'd0, REG_TAU, 31'd0, 1'b0, 16'sd0},
    '{ROW_CFG, 2'd0, FUNC_VEL, 32'sd0, 32'sd0, 8'd0, 20'd0, REG_LIM, 31'h7fff_ffff,
      1'b0, 16'sd0},
    '{ROW_TICK, 2'd2, FUNC_VEL, CMD_MAX, 32'sd0, 8'd0, 20'd0, REG_TAU, 31'd0, 1'b1,
      16'sd32767},
    '{ROW_TICK, 2'd1, FUNC_VEL, CMD_MIN, 32'sd0, 8'd0, 20'd0, REG_TAU, 31'd0, 1'b1,
      -16'sd32768}
  };

  joint_velocity_servo_with_strain_filter_core #(
    .NUM_JOINTS(NUM_JOINTS)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_joint            (in_joint),
    .in_func             (in_func),
    .in_command          (in_command),
    .in_measured_position(in_measured_position),
    .in_strain_raw       (in_strain_raw),
    .in_elapsed_us       (in_elapsed_us),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_joint_out       (out_joint_out),
    .out_velocity_counts (out_velocity_counts),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_wdata           (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic longint floor_quot(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  // round half up
  function automatic longint round_quot(longint n, longint d);
    return floor_quot(2 * n + d, 2 * d);
  endfunction

  function automatic servo_out_t servo_predict(servo_tick_t t);
    servo_out_t r;
    longint cmd, meas, raw, dt, lim, v, old, x, y, dx, s, qf, e, p, lim32, c;
    cmd  = $signed(t.command);
    meas = $signed(t.measured);
    raw  = t.raw;
    dt   = t.dt;
    lim  = cfg_vlimit;
    r.joint  = t.joint;
    r.counts = '0;
    if (t.joint >= NUM_JOINTS) return r;
    if (t.func == FUNC_VEL) begin
      v = cmd;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
    end else begin
      old = strain_state[t.joint];
      x = (raw - cfg_offset) * 65536;
      y = old;
      if (cfg_tau + dt != 0) y = round_quot(x * dt + old * cfg_tau, cfg_tau + dt);
      strain_state[t.joint] = y;
      dx = y - old;
      s = (dx < cfg_deadzone && dx > -cfg_deadzone) ? old : y;
      qf = round_quot(cfg_sgain * s, 65536);
      e = cmd - meas - qf;
      p = cfg_pgain * e;
      lim32 = lim * 65536;
      if (p > lim32) p = lim32;
      if (p < -lim32) p = -lim32;
      v = round_quot(p, 65536);
    end
    c = round_quot(v * cfg_cpr, 65536);
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    r.counts = c[CNT_W-1:0];
    return r;
  endfunction

  function automatic servo_tick_t random_tick();
    servo_tick_t t;
    int unsigned sel;
    int lvl;
    t.joint = ($urandom_range(15) == 0) ? JOINT_BAD : JW'($urandom_range(NUM_JOINTS - 1));
    t.func  = $urandom_range(1);
    // strain mostly drifts slowly per joint so the deadzone gets exercised
    if ($urandom_range(9) < 7) begin
      lvl = strain_level[t.joint] + int'($urandom_range(6)) - 3;
      strain_level[t.joint] = (lvl < 0) ? 0 : (lvl > 255) ? 255 : lvl;
    end else begin
      strain_level[t.joint] = $urandom_range(255);
    end
    t.raw = RAW_W'(strain_level[t.joint]);
    sel = $urandom_range(9);
    t.dt = (sel < 4) ? DT_W'($urandom_range(2000)) :
           (sel < 8) ? DT_W'($urandom_range(1000000)) :
           (sel == 8) ? '0 : DT_W'($urandom);
    t.measured = $urandom;
    if (t.func == FUNC_VEL)
      t.command = $urandom_range(1) ? CMD_W'($urandom) :
                  CMD_W'(int'($urandom_range(1 << 21)) - (1 << 20));
    else
      t.command = ($urandom_range(9) < 6) ?
                  t.measured + CMD_W'(int'($urandom_range(1 << 19)) - (1 << 18)) :
                  CMD_W'($urandom);
    return t;
  endfunction

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    case (idx)
      REG_TAU: cfg_tau      = data[TAU_W-1:0];
      REG_DZ:  cfg_deadzone = data[DZ_W-1:0];
      REG_OFF: cfg_offset   = data[OFF_W-1:0];
      REG_SG:  cfg_sgain    = data[SG_W-1:0];
      REG_PG:  cfg_pgain    = data[PG_W-1:0];
      REG_LIM: cfg_vlimit   = data[LIM_W-1:0];
      REG_CPR: cfg_cpr      = data[CPR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure_phase(int p);
    logic [CFG_DW-1:0] tau, dz, off, sg, pg, lim, cpr;
    case (p)
      0: begin
        tau = TAU_RST; dz = DZ_RST; off = OFF_RST; sg = SG_RST;
        pg = PG_RST; lim = LIM_RST; cpr = CPR_RST;
      end
      1: begin
        tau = 1; dz = 0; off = 0; sg = 0; pg = 0; lim = 0; cpr = 1;
      end
      2: begin
        tau = 4000000; dz = 16777215; off = 255; sg = 65535;
        pg = 65535; lim = 31'h7fff_ffff; cpr = 1048575;
      end
      default: begin
        tau = ($urandom_range(3) == 0) ? $urandom_range(2000, 1) : $urandom_range(4000000, 1);
        dz  = $urandom_range(1) ? $urandom_range(1 << 18) : $urandom_range(16777215);
        off = $urandom_range(255);
        sg  = $urandom_range(65535);
        pg  = $urandom_range(65535);
        lim = $urandom_range(1) ? $urandom_range(1 << 20) : $urandom_range(31'h7fff_ffff);
        cpr = ($urandom_range(3) == 0) ? $urandom_range(1048575, 1) : $urandom_range(100000, 1);
      end
    endcase
    write_reg(REG_TAU, tau);
    write_reg(REG_DZ, dz);
    write_reg(REG_OFF, off);
    write_reg(REG_SG, sg);
    write_reg(REG_PG, pg);
    write_reg(REG_LIM, lim);
    write_reg(REG_CPR, cpr);
  endtask

  // called and returns at a falling edge; valid stays high for back-to-back ticks
  task automatic drive_tick(servo_tick_t t, bit typed, logic signed [CNT_W-1:0] typed_counts);
    servo_out_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_joint             = t.joint;
    in_func              = t.func;
    in_command           = t.command;
    in_measured_position = t.measured;
    in_strain_raw        = t.raw;
    in_elapsed_us        = t.dt;
    in_valid             = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = servo_predict(t);
    if (typed) r.counts = typed_counts;
    expected_q.push_back(r);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) out_stall = ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    servo_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transfer: joint_out %0d velocity_counts %0d",
               out_joint_out, out_velocity_counts);
        error_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_joint_out !== exp_r.joint) begin
          $error("joint_out: expected %0d, actual %0d", exp_r.joint, out_joint_out);
          error_count++;
        end
        if (out_velocity_counts !== exp_r.counts) begin
          $error("velocity_counts: expected %0d, actual %0d", exp_r.counts,
                 out_velocity_counts);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    plan_row_t   row;
    servo_tick_t t;
    rst_n                = 1'b0;
    in_valid             = 1'b0;
    in_joint             = '0;
    in_func              = FUNC_VEL;
    in_command           = '0;
    in_measured_position = '0;
    in_strain_raw        = '0;
    in_elapsed_us        = '0;
    cfg_we               = 1'b0;
    cfg_idx              = REG_TAU;
    cfg_wdata            = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 50;
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_reg(row.reg_idx, row.reg_data);
      end else begin
        t = '{row.joint, row.func, row.command, row.measured, row.raw, row.dt};
        drive_tick(t, row.typed, row.typed_counts);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      send_idle_pct = (p < 3) ? 12 : (p < 6) ? 50 : 0;
      recv_idle_pct = (p < 3) ? 50 : (p < 6) ? 12 : 0;
      configure_phase(p);
      repeat (PHASE_TICKS) drive_tick(random_tick(), 1'b0, '0);
    end

    wait_idle();
    repeat (100) @(negedge clk);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
